FILE: hdl/rab_pkg.sv
package rab_pkg;

  // Input coordinate width and fraction bits of the coefficients.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Coefficient and result width.
  localparam int COEF_BITS  = 32;

  // Configuration register index width.
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_X_FROM_X = 3'd0,
    CFG_COEF_X_FROM_Y = 3'd1,
    CFG_OFFSET_X      = 3'd2,
    CFG_COEF_Y_FROM_X = 3'd3,
    CFG_COEF_Y_FROM_Y = 3'd4,
    CFG_OFFSET_Y      = 3'd5
  } cfg_reg_e;

  // Reset values: identity map, 1.0 on the diagonal.
  localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(64'd1 << FRAC_BITS);
  localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

endpackage

FILE: hdl/rect_affine_bounds_int.sv
// Timing: a beat taken with start_i shows on the result ports with done_o after the input,
// multiply, min/max, sum, floor/ceil and extent stages.
// Throughput: one rectangle per cycle; busy_o stays low, the pipeline never stalls.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the identity map.
module rect_affine_bounds_int (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [rab_pkg::COORD_BITS-1:0] rect_x_i,
  input  logic signed [rab_pkg::COORD_BITS-1:0] rect_y_i,
  input  logic        [rab_pkg::COORD_BITS-1:0] rect_width_i,
  input  logic        [rab_pkg::COORD_BITS-1:0] rect_height_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rab_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [rab_pkg::COEF_BITS-1:0]       cfg_data_i,
  output logic                                done_o,
  output logic signed [rab_pkg::COEF_BITS-1:0] box_x_o,
  output logic signed [rab_pkg::COEF_BITS-1:0] box_y_o,
  output logic        [rab_pkg::COEF_BITS-1:0] box_width_o,
  output logic        [rab_pkg::COEF_BITS-1:0] box_height_o,
  output logic                                clipped_o
);
  import rab_pkg::*;

  // Corner coordinate, product, sum and extent widths.
  localparam int PW  = COORD_BITS + 2;
  localparam int PRW = PW + COEF_BITS;
  localparam int SW  = PRW + 2;
  localparam int CW  = SW + 1;
  localparam int EW  = SW + 2;

  localparam logic signed [SW-1:0] BOX_MAX = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] BOX_MIN = SW'(-64'sh8000_0000);
  localparam logic signed [EW-1:0] EXT_MAX = EW'(64'sh0000_0000_FFFF_FFFF);
  localparam logic signed [CW-1:0] FMASK   = CW'((64'd1 << FRAC_BITS) - 64'd1);

  logic accept;
  assign accept      = start_i && !busy_o;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic signed [COEF_BITS-1:0] cxx_q, cxy_q, ox_q, cyx_q, cyy_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cxx_q <= COEF_ONE;
      cxy_q <= COEF_ZERO;
      ox_q  <= COEF_ZERO;
      cyx_q <= COEF_ZERO;
      cyy_q <= COEF_ONE;
      oy_q  <= COEF_ZERO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_COEF_X_FROM_X: cxx_q <= cfg_data_i;
        CFG_COEF_X_FROM_Y: cxy_q <= cfg_data_i;
        CFG_OFFSET_X:      ox_q  <= cfg_data_i;
        CFG_COEF_Y_FROM_X: cyx_q <= cfg_data_i;
        CFG_COEF_Y_FROM_Y: cyy_q <= cfg_data_i;
        CFG_OFFSET_Y:      oy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the beat through the stages.
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  assign done_o = vld_q[5];

  // Stage 0: corner coordinates of the rectangle.
  logic signed [PW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [PW-1:0] x0_d, y0_d;

  assign x0_d = {{2{rect_x_i[COORD_BITS-1]}}, rect_x_i};
  assign y0_d = {{2{rect_y_i[COORD_BITS-1]}}, rect_y_i};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      x1_q <= x0_d + $signed({2'b00, rect_width_i});
      y1_q <= y0_d + $signed({2'b00, rect_height_i});
    end
  end

  // Stage 1: each coefficient times both coordinates it weights.
  logic signed [PRW-1:0] pxa0_q, pxa1_q, pxb0_q, pxb1_q;
  logic signed [PRW-1:0] pya0_q, pya1_q, pyb0_q, pyb1_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      pxa0_q <= cxx_q * x0_q;
      pxa1_q <= cxx_q * x1_q;
      pxb0_q <= cxy_q * y0_q;
      pxb1_q <= cxy_q * y1_q;
      pya0_q <= cyx_q * x0_q;
      pya1_q <= cyx_q * x1_q;
      pyb0_q <= cyy_q * y0_q;
      pyb1_q <= cyy_q * y1_q;
    end
  end

  // Stage 2: the map is separable, so the corner extremes are sums of per-term extremes.
  logic signed [PRW-1:0] xa_lo_q, xa_hi_q, xb_lo_q, xb_hi_q;
  logic signed [PRW-1:0] ya_lo_q, ya_hi_q, yb_lo_q, yb_hi_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      xa_lo_q <= (pxa0_q < pxa1_q) ? pxa0_q : pxa1_q;
      xa_hi_q <= (pxa0_q < pxa1_q) ? pxa1_q : pxa0_q;
      xb_lo_q <= (pxb0_q < pxb1_q) ? pxb0_q : pxb1_q;
      xb_hi_q <= (pxb0_q < pxb1_q) ? pxb1_q : pxb0_q;
      ya_lo_q <= (pya0_q < pya1_q) ? pya0_q : pya1_q;
      ya_hi_q <= (pya0_q < pya1_q) ? pya1_q : pya0_q;
      yb_lo_q <= (pyb0_q < pyb1_q) ? pyb0_q : pyb1_q;
      yb_hi_q <= (pyb0_q < pyb1_q) ? pyb1_q : pyb0_q;
    end
  end

  // Stage 3: smallest and largest mapped coordinate on each axis.
  logic signed [SW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      min_x_q <= SW'(xa_lo_q) + SW'(xb_lo_q) + SW'(ox_q);
      max_x_q <= SW'(xa_hi_q) + SW'(xb_hi_q) + SW'(ox_q);
      min_y_q <= SW'(ya_lo_q) + SW'(yb_lo_q) + SW'(oy_q);
      max_y_q <= SW'(ya_hi_q) + SW'(yb_hi_q) + SW'(oy_q);
    end
  end

  // Stage 4: floor of the minimum with saturation, ceiling of the maximum.
  logic signed [SW-1:0] flr_x, flr_y;
  logic signed [CW-1:0] cel_x_d, cel_y_d;
  logic signed [SW-1:0] bx_d, by_d;
  logic                 clip_x_d, clip_y_d;

  assign flr_x   = min_x_q >>> FRAC_BITS;
  assign flr_y   = min_y_q >>> FRAC_BITS;
  assign cel_x_d = (CW'(max_x_q) + FMASK) >>> FRAC_BITS;
  assign cel_y_d = (CW'(max_y_q) + FMASK) >>> FRAC_BITS;

  always_comb begin
    bx_d     = flr_x;
    by_d     = flr_y;
    clip_x_d = 1'b0;
    clip_y_d = 1'b0;
    if (flr_x > BOX_MAX) begin
      bx_d     = BOX_MAX;
      clip_x_d = 1'b1;
    end else if (flr_x < BOX_MIN) begin
      bx_d     = BOX_MIN;
      clip_x_d = 1'b1;
    end
    if (flr_y > BOX_MAX) begin
      by_d     = BOX_MAX;
      clip_y_d = 1'b1;
    end else if (flr_y < BOX_MIN) begin
      by_d     = BOX_MIN;
      clip_y_d = 1'b1;
    end
  end

  logic signed [COEF_BITS-1:0] bx_q, by_q;
  logic signed [CW-1:0]        cel_x_q, cel_y_q;
  logic                        clip_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      bx_q    <= bx_d[COEF_BITS-1:0];
      by_q    <= by_d[COEF_BITS-1:0];
      cel_x_q <= cel_x_d;
      cel_y_q <= cel_y_d;
      clip_q  <= clip_x_d || clip_y_d;
    end
  end

  // Stage 5: extent against the saturated corner, clamped to the unsigned range.
  logic signed [EW-1:0] ext_w, ext_h, bw_d, bh_d;
  logic                 clip_w_d, clip_h_d;

  assign ext_w = EW'(cel_x_q) - EW'(bx_q);
  assign ext_h = EW'(cel_y_q) - EW'(by_q);

  always_comb begin
    bw_d     = ext_w;
    bh_d     = ext_h;
    clip_w_d = 1'b0;
    clip_h_d = 1'b0;
    if (ext_w > EXT_MAX) begin
      bw_d     = EXT_MAX;
      clip_w_d = 1'b1;
    end else if (ext_w < 0) begin
      bw_d     = '0;
      clip_w_d = 1'b1;
    end
    if (ext_h > EXT_MAX) begin
      bh_d     = EXT_MAX;
      clip_h_d = 1'b1;
    end else if (ext_h < 0) begin
      bh_d     = '0;
      clip_h_d = 1'b1;
    end
  end

  // Output register, shown for one cycle under done_o.
  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      box_x_o      <= bx_q;
      box_y_o      <= by_q;
      box_width_o  <= bw_d[COEF_BITS-1:0];
      box_height_o <= bh_d[COEF_BITS-1:0];
      clipped_o    <= clip_q || clip_w_d || clip_h_d;
    end
  end

`ifndef SYNTH
  // Every accepted beat comes out with done_o at the end of the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 done_o)
    else $error("accepted beat did not produce a result");

  // No result appears without an earlier accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 6))
    else $error("result without an accepted beat");

  // Any saturation flagged in the floor/ceil or extent stage reaches clipped_o together with done_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && (clip_w_d || clip_h_d || clip_q)) |=> (done_o && clipped_o))
    else $error("saturation flag lost on the way to the output");
`endif

endmodule
